// ----- rtl/incremental_pid_with_deadband_assert.svh -----
// ----------------------------------------------------------------------------
// incremental pid assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_WITH_DEADBAND_ASSERT_SVH
`define INCREMENTAL_PID_WITH_DEADBAND_ASSERT_SVH

`ifndef ASSERT_OFF
`define IPID_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define IPID_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define IPID_ASSERT(lbl, clk, rst, prop)
`define IPID_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ----- rtl/ipid_pkg.sv -----
// ----------------------------------------------------------------------------
// ipid_pkg
// shared types and codes of the incremental pid controller
// ----------------------------------------------------------------------------
package ipid_pkg;

   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth  = 32;
   localparam int GainWidth     = 24;
   localparam int LimitWidth    = 32;
   localparam int BandWidth     = 17;
   localparam int SampleWidth   = 16;
   localparam int ErrorWidth    = 17;
   localparam int ProductWidth  = GainWidth + ErrorWidth;
   localparam int SumWidth      = ProductWidth + 3;

   localparam logic [CsrIndexWidth-1:0] CsrGainNow     = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CsrGainOneBack = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CsrGainTwoBack = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CsrLimitA      = 8'd3;
   localparam logic [CsrIndexWidth-1:0] CsrLimitB      = 8'd4;
   localparam logic [CsrIndexWidth-1:0] CsrDeadBand    = 8'd5;

   localparam logic [1:0] KindZero = 2'd0;
   localparam logic [1:0] KindHold = 2'd1;
   localparam logic [1:0] KindSum  = 2'd2;

   typedef struct packed {
      logic signed [GainWidth-1:0]  gain_now;
      logic signed [GainWidth-1:0]  gain_one_back;
      logic signed [GainWidth-1:0]  gain_two_back;
      logic signed [LimitWidth-1:0] upper;
      logic signed [LimitWidth-1:0] lower;
      logic        [BandWidth-1:0]  dead_band;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                     kind;
      logic signed [ProductWidth-1:0] p_now;
      logic signed [ProductWidth-1:0] p_one;
      logic signed [ProductWidth-1:0] p_two;
   } terms_type;

endpackage

// ----- rtl/ipid_csr.sv -----
// ----------------------------------------------------------------------------
// ipid_csr
// configuration registers, limits sorted into upper and lower
// ----------------------------------------------------------------------------
module ipid_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ipid_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [ipid_pkg::CsrDataWidth-1:0]    csr_data,
   output ipid_pkg::cfg_type                    cfg
);

   logic signed [ipid_pkg::GainWidth-1:0]  gain_now_ff, gain_one_ff, gain_two_ff;
   logic signed [ipid_pkg::LimitWidth-1:0] limit_a_ff, limit_b_ff;
   logic signed [ipid_pkg::LimitWidth-1:0] upper_ff, lower_ff, upper_in, lower_in;
   logic        [ipid_pkg::BandWidth-1:0]  band_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_now_ff <= '0;
         gain_one_ff <= '0;
         gain_two_ff <= '0;
         limit_a_ff  <= '0;
         limit_b_ff  <= '0;
         band_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ipid_pkg::CsrGainNow:     gain_now_ff <= csr_data[ipid_pkg::GainWidth-1:0];
            ipid_pkg::CsrGainOneBack: gain_one_ff <= csr_data[ipid_pkg::GainWidth-1:0];
            ipid_pkg::CsrGainTwoBack: gain_two_ff <= csr_data[ipid_pkg::GainWidth-1:0];
            ipid_pkg::CsrLimitA:      limit_a_ff  <= csr_data[ipid_pkg::LimitWidth-1:0];
            ipid_pkg::CsrLimitB:      limit_b_ff  <= csr_data[ipid_pkg::LimitWidth-1:0];
            ipid_pkg::CsrDeadBand:    band_ff     <= csr_data[ipid_pkg::BandWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (limit_a_ff > limit_b_ff) begin
         upper_in = limit_a_ff;
         lower_in = limit_b_ff;
      end else begin
         upper_in = limit_b_ff;
         lower_in = limit_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= '0;
         lower_ff <= '0;
      end else begin
         upper_ff <= upper_in;
         lower_ff <= lower_in;
      end
   end

   assign cfg.gain_now      = gain_now_ff;
   assign cfg.gain_one_back = gain_one_ff;
   assign cfg.gain_two_back = gain_two_ff;
   assign cfg.upper         = upper_ff;
   assign cfg.lower         = lower_ff;
   assign cfg.dead_band     = band_ff;

endmodule

// ----- rtl/ipid_front.sv -----
// ----------------------------------------------------------------------------
// ipid_front
// input register, error forming, error history and the three products
// ----------------------------------------------------------------------------
module ipid_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [ipid_pkg::SampleWidth-1:0] measurement,
   input  logic signed [ipid_pkg::SampleWidth-1:0] target,
   input  ipid_pkg::cfg_type                    cfg,
   output logic                                 terms_valid,
   input  logic                                 terms_ready,
   output ipid_pkg::terms_type                  terms
);

   logic                                       s0_valid_ff;
   logic signed [ipid_pkg::SampleWidth-1:0]    meas_ff, tgt_ff;
   logic signed [ipid_pkg::ErrorWidth-1:0]     err, e1_ff, e2_ff;
   logic        [ipid_pkg::ErrorWidth-1:0]     mag;
   logic                                       s1_valid_ff;
   logic                                       s0_adv, s1_free;
   ipid_pkg::terms_type                        terms_ff, terms_in;

   assign s1_free  = !s1_valid_ff || terms_ready;
   assign s0_adv   = s0_valid_ff && s1_free;
   assign in_ready = !s0_valid_ff || s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         meas_ff <= measurement;
         tgt_ff  <= target;
      end
   end

   always_comb begin
      err = ipid_pkg::ErrorWidth'(tgt_ff) - ipid_pkg::ErrorWidth'(meas_ff);
      mag = err[ipid_pkg::ErrorWidth-1] ? ipid_pkg::ErrorWidth'(-err)
                                        : ipid_pkg::ErrorWidth'(err);
      priority if (tgt_ff == '0 && meas_ff == '0) begin
         terms_in.kind = ipid_pkg::KindZero;
      end else if (mag < cfg.dead_band) begin
         terms_in.kind = ipid_pkg::KindHold;
      end else begin
         terms_in.kind = ipid_pkg::KindSum;
      end
      terms_in.p_now = ipid_pkg::ProductWidth'(cfg.gain_now)      * ipid_pkg::ProductWidth'(err);
      terms_in.p_one = ipid_pkg::ProductWidth'(cfg.gain_one_back) * ipid_pkg::ProductWidth'(e1_ff);
      terms_in.p_two = ipid_pkg::ProductWidth'(cfg.gain_two_back) * ipid_pkg::ProductWidth'(e2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ff       <= '0;
         e2_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (s0_adv) begin
            e1_ff <= err;
            e2_ff <= e1_ff;
         end
         if (s1_free) begin
            s1_valid_ff <= s0_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_adv) begin
         terms_ff <= terms_in;
      end
   end

   assign terms_valid = s1_valid_ff;
   assign terms       = terms_ff;

endmodule

// ----- rtl/ipid_back.sv -----
// ----------------------------------------------------------------------------
// ipid_back
// accumulate onto the last drive and clamp, or zero or hold it, and hold the result register
// ----------------------------------------------------------------------------
`include "incremental_pid_with_deadband_assert.svh"

module ipid_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 terms_valid,
   output logic                                 terms_ready,
   input  ipid_pkg::terms_type                  terms,
   input  ipid_pkg::cfg_type                    cfg,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [ipid_pkg::LimitWidth-1:0] drive
);

   logic                                       out_valid_ff;
   logic signed [ipid_pkg::LimitWidth-1:0]     last_ff, drive_ff, drive_in;
   logic signed [ipid_pkg::SumWidth-1:0]       sum;
   logic                                       adv;

   assign terms_ready = !out_valid_ff || out_ready;
   assign adv         = terms_valid && terms_ready;

   always_comb begin
      sum = ipid_pkg::SumWidth'(last_ff)
          + ipid_pkg::SumWidth'(terms.p_now)
          + ipid_pkg::SumWidth'(terms.p_one)
          + ipid_pkg::SumWidth'(terms.p_two);
      unique case (terms.kind)
         ipid_pkg::KindZero: drive_in = '0;
         ipid_pkg::KindHold: drive_in = last_ff;
         default: begin
            priority if (sum > ipid_pkg::SumWidth'(cfg.upper)) begin
               drive_in = cfg.upper;
            end else if (sum < ipid_pkg::SumWidth'(cfg.lower)) begin
               drive_in = cfg.lower;
            end else begin
               drive_in = sum[ipid_pkg::LimitWidth-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            last_ff <= drive_in;
         end
         if (terms_ready) begin
            out_valid_ff <= terms_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         drive_ff <= drive_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign drive     = drive_ff;

   `IPID_ASSERT(a_zero_case, clock, reset,
      adv && terms.kind == ipid_pkg::KindZero |=> drive_ff == '0 && last_ff == '0)
   `IPID_ASSERT(a_hold_case, clock, reset,
      adv && terms.kind == ipid_pkg::KindHold |=> drive_ff == $past(last_ff))
   `IPID_ASSERT(a_clamped, clock, reset,
      adv && terms.kind == ipid_pkg::KindSum |=>
         drive_ff <= $past(cfg.upper) && drive_ff >= $past(cfg.lower))
   `IPID_ASSERT(a_last_tracks, clock, reset,
      adv |=> last_ff == drive_ff)

endmodule

// ----- rtl/incremental_pid_with_deadband.sv -----
// ----------------------------------------------------------------------------
// incremental_pid_with_deadband
// velocity-form pid with dead band and sorted output clamp
//
//   channel   dir   payload (low bit up)              handshake
//   req_      in    tdata: measurement, target        tvalid / tready
//   rsp_      out   tdata: drive                      tvalid / tready
//   csr_      in    index, data                       valid / ready
//
// one sample per cycle sustained while rsp_tready stays high; a result passes
// through the input, product and result registers after its transfer
// the loop through the last drive is a combinational add and clamp
// synchronous reset clears the gains, limits, error history and last drive
// a stalled result backs up the three stages, then req_tready drops
// ----------------------------------------------------------------------------
`include "incremental_pid_with_deadband_assert.svh"

module incremental_pid_with_deadband (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,   // measurement, target
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [31:0]                        rsp_tdata,   // drive
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ipid_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ipid_pkg::CsrDataWidth-1:0]  csr_data
);

   ipid_pkg::cfg_type                          cfg;
   ipid_pkg::terms_type                        terms;
   logic                                       terms_valid, terms_ready;
   logic signed [ipid_pkg::LimitWidth-1:0]     drive;

   ipid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ipid_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .measurement (req_tdata[15:0]),
      .target      (req_tdata[31:16]),
      .cfg         (cfg),
      .terms_valid (terms_valid),
      .terms_ready (terms_ready),
      .terms       (terms)
   );

   ipid_back u_back (
      .clock       (clock),
      .reset       (reset),
      .terms_valid (terms_valid),
      .terms_ready (terms_ready),
      .terms       (terms),
      .cfg         (cfg),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .drive       (drive)
   );

   assign rsp_tdata = drive;

   `IPID_ASSERT(a_backpressure_source, clock, reset,
      !req_tready |-> rsp_tvalid && !rsp_tready)
   `IPID_NEVER(a_csr_stall, clock, reset, !csr_ready)

endmodule
